// File: hw/rtl/wss_pkg.sv
package wss_pkg;

    // Window length is 2**WINDOW_LOG2 samples
    localparam int WINDOW_LOG2 = 10;

    // Sample and product widths
    localparam int RAW_W = 12;
    localparam int CEN_W = 13;
    localparam int PROD_W = 2 * CEN_W;
    localparam int SQ_W = 24;

    // Accumulator widths grow with the window
    localparam int CNT_W = WINDOW_LOG2;
    localparam int SUM_W = CEN_W + WINDOW_LOG2;
    localparam int SQSUM_W = SQ_W + WINDOW_LOG2;
    localparam int EXT_W = WINDOW_LOG2 + 1;

    // Result field widths
    localparam int MEAN_W = 23;
    localparam int MSQ_W = 34;
    localparam int EXTOUT_W = 11;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam logic [RAW_W-1:0] MIDPOINT_RST = 12'd2048;
    localparam logic signed [CEN_W-1:0] CEN_MAX = 13'sd4095;
    localparam logic signed [CEN_W-1:0] CEN_MIN = -13'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIDPOINT = 2'd0,
        REG_UPPER    = 2'd1,
        REG_LOWER    = 2'd2
    } cfg_reg_t;

    // One centered sample with its square and band check
    typedef struct packed {
        logic signed [CEN_W-1:0] centered;
        logic [SQ_W-1:0]         square;
        logic                    extremal;
    } sample_t;

    // Accumulator handshake status seen by the front stages
    typedef struct packed {
        logic take;
        logic last;
    } acc_status_t;

endpackage

// File: hw/rtl/windowed_sample_statistics_top.sv
// Windowed sample statistics, one converter channel.
// Input channel s_valid/s_ready carries one 12-bit raw sample per beat.
// Each sample is centered by the midpoint register; over a window of
// 2**WINDOW_LOG2 samples the block sums the centered values and their
// squares, tracks max and min, and counts samples outside the threshold band.
// One result beat on m_valid/m_ready follows the last sample of each window;
// other samples produce nothing. Mean and mean square are the plain sums,
// read as fixed point with WINDOW_LOG2 fraction bits.
// Throughput: one sample per cycle while no window end waits on a stalled
// result, set by the three-stage pipeline (input register, center/square
// register, accumulate/result register); the result leaves the last stage.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready, index 0 midpoint, 1 upper threshold, 2 lower threshold, 3 ignored.
// Write it only while no window samples are in flight.
// Reset (aresetn low, synchronous) restores register defaults and starts an
// empty window. When the receiver stalls, the result register holds; samples
// keep flowing until the next window end, which then waits, and s_ready drops
// once the stages behind it fill up.
module windowed_sample_statistics_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wss_pkg::RAW_W-1:0]           s_raw_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wss_pkg::MEAN_W-1:0]   m_window_mean,
    output logic [wss_pkg::MSQ_W-1:0]           m_window_mean_square,
    output logic signed [wss_pkg::CEN_W-1:0]    m_window_max,
    output logic signed [wss_pkg::CEN_W-1:0]    m_window_min,
    output logic [wss_pkg::EXTOUT_W-1:0]        m_extremal_total,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wss_pkg::*;

    logic [RAW_W-1:0]          mid_reg;
    logic signed [CEN_W-1:0]   upper_reg;
    logic signed [CEN_W-1:0]   lower_reg;

    logic                      in_valid_reg;
    logic [RAW_W-1:0]          raw_reg;
    logic                      sq_valid_reg;
    sample_t                   sq_reg;
    sample_t                   sq_next;
    logic signed [PROD_W-1:0]  prod;
    logic                      sq_load;
    acc_status_t               acc_status;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg   <= MIDPOINT_RST;
            upper_reg <= CEN_MAX;
            lower_reg <= CEN_MIN;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_MIDPOINT: mid_reg <= cfg_data[RAW_W-1:0];
                REG_UPPER:    upper_reg <= $signed(cfg_data[CEN_W-1:0]);
                REG_LOWER:    lower_reg <= $signed(cfg_data[CEN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Stage moves forward when the stage behind it is free or draining
    assign sq_load = !sq_valid_reg || acc_status.take;
    assign s_ready = !in_valid_reg || sq_load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (sq_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_sample;
        end
    end

    // Center, square and band check
    always_comb begin
        sq_next.centered = $signed({1'b0, raw_reg}) - $signed({1'b0, mid_reg});
        prod             = sq_next.centered * sq_next.centered;
        sq_next.square   = prod[SQ_W-1:0];
        sq_next.extremal = (sq_next.centered > upper_reg) ||
                           (sq_next.centered < lower_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (sq_load) begin
            sq_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_load && in_valid_reg) begin
            sq_reg <= sq_next;
        end
    end

    // Accumulate over the window and hold the result
    wss_accum u_accum (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .sq_valid             (sq_valid_reg),
        .sq_data              (sq_reg),
        .acc_status           (acc_status),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_window_mean        (m_window_mean),
        .m_window_mean_square (m_window_mean_square),
        .m_window_max         (m_window_max),
        .m_window_min         (m_window_min),
        .m_extremal_total     (m_extremal_total)
    );

`ifndef SYNTH
    // A new result appears only after a window's last sample was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(acc_status.take && acc_status.last))
        else $error("result raised without a window end");

    // A stalled result is never overwritten by the next window end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !(acc_status.take && acc_status.last))
        else $error("window end taken while result stalled");

    // The accumulator only consumes real samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_status.take |-> sq_valid_reg)
        else $error("accumulator took an empty stage");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

// File: hw/rtl/wss_accum.sv
module wss_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              sq_valid,
    input  wss_pkg::sample_t                  sq_data,
    output wss_pkg::acc_status_t              acc_status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [wss_pkg::MEAN_W-1:0] m_window_mean,
    output logic [wss_pkg::MSQ_W-1:0]         m_window_mean_square,
    output logic signed [wss_pkg::CEN_W-1:0]  m_window_max,
    output logic signed [wss_pkg::CEN_W-1:0]  m_window_min,
    output logic [wss_pkg::EXTOUT_W-1:0]      m_extremal_total
);
    import wss_pkg::*;

    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQSUM_W-1:0]        sqsum_reg;
    logic signed [CEN_W-1:0]   max_reg;
    logic signed [CEN_W-1:0]   min_reg;
    logic [EXT_W-1:0]          ext_reg;

    logic signed [SUM_W-1:0]   sum_next;
    logic [SQSUM_W-1:0]        sqsum_next;
    logic signed [CEN_W-1:0]   max_next;
    logic signed [CEN_W-1:0]   min_next;
    logic [EXT_W-1:0]          ext_next;

    logic                      last;
    logic                      take;

    logic                      out_valid_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [MSQ_W-1:0]          msq_reg;
    logic signed [CEN_W-1:0]   omax_reg;
    logic signed [CEN_W-1:0]   omin_reg;
    logic [EXTOUT_W-1:0]       oext_reg;

    // Last beat of the window; hold it while the result register is full and not being read
    assign last = (cnt_reg == {CNT_W{1'b1}});
    assign take = sq_valid && !(last && out_valid_reg && !m_ready);
    assign acc_status.take = take;
    assign acc_status.last = last;

    // Fold the current sample into the running values
    always_comb begin
        sum_next   = sum_reg + SUM_W'(sq_data.centered);
        sqsum_next = sqsum_reg + SQSUM_W'(sq_data.square);
        max_next   = (sq_data.centered > max_reg) ? sq_data.centered : max_reg;
        min_next   = (sq_data.centered < min_reg) ? sq_data.centered : min_reg;
        ext_next   = ext_reg + EXT_W'(sq_data.extremal);
    end

    // Advance accumulators, clear them after the last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            max_reg   <= CEN_MIN;
            min_reg   <= CEN_MAX;
            ext_reg   <= '0;
        end else if (take) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last) begin
                sum_reg   <= '0;
                sqsum_reg <= '0;
                max_reg   <= CEN_MIN;
                min_reg   <= CEN_MAX;
                ext_reg   <= '0;
            end else begin
                sum_reg   <= sum_next;
                sqsum_reg <= sqsum_next;
                max_reg   <= max_next;
                min_reg   <= min_next;
                ext_reg   <= ext_next;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, wrapped to the field widths
    always_ff @(posedge aclk) begin
        if (take && last) begin
            mean_reg <= MEAN_W'(sum_next);
            msq_reg  <= MSQ_W'(sqsum_next);
            omax_reg <= max_next;
            omin_reg <= min_next;
            oext_reg <= EXTOUT_W'(ext_next);
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_window_mean        = mean_reg;
    assign m_window_mean_square = msq_reg;
    assign m_window_max         = omax_reg;
    assign m_window_min         = omin_reg;
    assign m_extremal_total     = oext_reg;

endmodule

// File: tb/windowed_sample_statistics_top_test.sv
`timescale 1ns / 100ps

module windowed_sample_statistics_top_test;

    import wss_pkg::*;

    localparam int WINDOW_LEN = 1 << WINDOW_LOG2;
    localparam int DRAIN_CYCLES = 8;
    localparam int WINDOW_TARGET = 60;
    localparam int PLAN_LEN = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One window result as it appears on the result channel
    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [MSQ_W-1:0]         mean_square;
        logic signed [CEN_W-1:0]  max;
        logic signed [CEN_W-1:0]  min;
        logic [EXTOUT_W-1:0]      extremal;
    } window_stats_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_FILL
    } row_kind_t;

    typedef enum logic [1:0] {
        MODE_RAMP,
        MODE_UNIFORM,
        MODE_NEAR,
        MODE_RAILS
    } sample_mode_t;

    // One step of the directed plan: a register write or a run of samples
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]   data;
        logic [RAW_W-1:0]        start;
        logic signed [15:0]      step;
        logic [15:0]             count;
        logic                    known;
        window_stats_t           want;
    } plan_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCK
    } rx_mode_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [MEAN_W-1:0] m_window_mean;
    logic [MSQ_W-1:0]         m_window_mean_square;
    logic signed [CEN_W-1:0]  m_window_max;
    logic signed [CEN_W-1:0]  m_window_min;
    logic [EXTOUT_W-1:0]      m_extremal_total;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    windowed_sample_statistics_top u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_raw_sample         (s_raw_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_window_mean        (m_window_mean),
        .m_window_mean_square (m_window_mean_square),
        .m_window_max         (m_window_max),
        .m_window_min         (m_window_min),
        .m_extremal_total     (m_extremal_total),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    // Shadow registers and window accumulators
    logic [RAW_W-1:0]          mid_reg = MIDPOINT_RST;
    logic signed [CEN_W-1:0]   upper_reg = CEN_MAX;
    logic signed [CEN_W-1:0]   lower_reg = CEN_MIN;
    logic [WINDOW_LOG2:0]      win_count = '0;
    logic signed [23:0]        win_sum = '0;
    logic [34:0]               win_sq_sum = '0;
    logic signed [CEN_W-1:0]   win_max = CEN_MIN;
    logic signed [CEN_W-1:0]   win_min = CEN_MAX;
    logic [10:0]               win_extremal = '0;

    window_stats_t expected_windows [$];
    int            windows_predicted = 0;
    bit            failed = 0;

    // Known-answer override for the directed windows
    bit            known_on = 0;
    window_stats_t known_want;

    // Sender burst state
    int            burst_left = 0;
    bit            quiet = 0;

    plan_row_t     plan [PLAN_LEN];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic window_stats_t win_stats(input logic signed [MEAN_W-1:0] mean,
                                                input logic [MSQ_W-1:0] msq,
                                                input logic signed [CEN_W-1:0] mx,
                                                input logic signed [CEN_W-1:0] mn,
                                                input logic [EXTOUT_W-1:0] ext);
        win_stats = '{mean: mean, mean_square: msq, max: mx, min: mn, extremal: ext};
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        write_row = '{kind: ROW_WRITE, index: idx, data: data, start: '0, step: '0,
                      count: '0, known: 1'b0, want: '0};
    endfunction

    function automatic plan_row_t fill_row(input logic [RAW_W-1:0] start, input int step,
                                           input int count);
        fill_row = '{kind: ROW_FILL, index: '0, data: '0, start: start, step: 16'(step),
                     count: 16'(count), known: 1'b0, want: '0};
    endfunction

    function automatic plan_row_t known_row(input logic [RAW_W-1:0] sample,
                                            input window_stats_t want);
        known_row = fill_row(sample, 0, WINDOW_LEN);
        known_row.known = 1'b1;
        known_row.want = want;
    endfunction

    // Fold one accepted sample into the window; queue the result at window end
    function automatic void accumulate_sample(input logic [RAW_W-1:0] raw);
        logic signed [CEN_W-1:0]  c;
        logic signed [2*CEN_W-1:0] sq;
        window_stats_t got;
        c = $signed({1'b0, raw}) - $signed({1'b0, mid_reg});
        sq = c * c;
        win_sum = win_sum + c;
        win_sq_sum = win_sq_sum + 35'(unsigned'(sq));
        if (c > win_max) win_max = c;
        if (c < win_min) win_min = c;
        if (c > upper_reg || c < lower_reg) win_extremal = win_extremal + 1'b1;
        win_count = win_count + 1'b1;
        if (win_count == WINDOW_LEN) begin
            got = win_stats(win_sum[MEAN_W-1:0], win_sq_sum[MSQ_W-1:0], win_max, win_min,
                            win_extremal[EXTOUT_W-1:0]);
            expected_windows.push_back(known_on ? known_want : got);
            windows_predicted++;
            win_count = '0;
            win_sum = '0;
            win_sq_sum = '0;
            win_max = CEN_MIN;
            win_min = CEN_MAX;
            win_extremal = '0;
        end
    endfunction

    // Stop sending, drain the block, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIDPOINT: mid_reg = data[RAW_W-1:0];
            REG_UPPER:    upper_reg = $signed(data);
            REG_LOWER:    lower_reg = $signed(data);
            default:      ;
        endcase
    endtask

    // Send a run of samples in bursts with random gaps; valid stays up at the end
    task automatic send_run(input sample_mode_t mode, input logic [RAW_W-1:0] base,
                            input int step, input int count);
        logic [RAW_W-1:0] cur;
        int               gap;
        int               t;
        cur = base;
        for (int i = 0; i < count; i++) begin
            case (mode)
                MODE_UNIFORM: cur = RAW_W'($urandom_range(0, 4095));
                MODE_NEAR: begin
                    t = int'(base) + int'($urandom_range(0, 2 * step)) - step;
                    cur = RAW_W'((t < 0) ? 0 : ((t > 4095) ? 4095 : t));
                end
                MODE_RAILS: begin
                    if ($urandom_range(0, 3) == 0) cur = RAW_W'($urandom);
                    else cur = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                end
                default: if (i != 0) cur = cur + RAW_W'(step);
            endcase
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = quiet ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            s_valid <= 1'b1;
            s_raw_sample <= cur;
            do @(posedge aclk); while (!s_ready);
            accumulate_sample(cur);
        end
    endtask

    // Receiver stall pattern
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(10, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    // Compare each result beat with the oldest expected window
    always @(posedge aclk) begin : check_results
        window_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_windows.size() == 0) begin
                $error("result beat with no window expected");
                failed = 1;
            end else begin
                want = expected_windows.pop_front();
                if (m_window_mean !== want.mean) begin
                    $error("window_mean: expected %0d, got %0d", want.mean, m_window_mean);
                    failed = 1;
                end
                if (m_window_mean_square !== want.mean_square) begin
                    $error("window_mean_square: expected %0d, got %0d", want.mean_square,
                           m_window_mean_square);
                    failed = 1;
                end
                if (m_window_max !== want.max) begin
                    $error("window_max: expected %0d, got %0d", want.max, m_window_max);
                    failed = 1;
                end
                if (m_window_min !== want.min) begin
                    $error("window_min: expected %0d, got %0d", want.min, m_window_min);
                    failed = 1;
                end
                if (m_extremal_total !== want.extremal) begin
                    $error("extremal_total: expected %0d, got %0d", want.extremal,
                           m_extremal_total);
                    failed = 1;
                end
            end
        end
    end

    initial begin : stimulus
        sample_mode_t mode;
        logic [CFG_DATA_W-1:0] value;

        // Defaults first: centered zero, then both rails
        plan[0]  = known_row(12'd2048, win_stats(0, 0, 0, 0, 0));
        plan[1]  = known_row(12'd4095, win_stats(23'sd2096128, 34'd4290774016,
                                                 13'sd2047, 13'sd2047, 0));
        plan[2]  = known_row(12'd0, win_stats(-23'sd2097152, 34'd4294967296,
                                              -13'sd2048, -13'sd2048, 0));
        // Full centered range; thresholds at their limits are never crossed
        plan[3]  = write_row(REG_MIDPOINT, 13'd0);
        plan[4]  = known_row(12'd4095, win_stats(23'sd4193280, 34'd17171481600,
                                                 13'sd4095, 13'sd4095, 0));
        plan[5]  = write_row(REG_MIDPOINT, 13'd4095);
        plan[6]  = known_row(12'd0, win_stats(-23'sd4193280, 34'd17171481600,
                                              -13'sd4095, -13'sd4095, 0));
        // Every sample below a zero lower threshold
        plan[7]  = write_row(REG_UPPER, 13'd0);
        plan[8]  = write_row(REG_LOWER, 13'd0);
        plan[9]  = known_row(12'd0, win_stats(-23'sd4193280, 34'd17171481600,
                                              -13'sd4095, -13'sd4095, 11'd1024));
        // Midpoint drops the top data bit; crossed thresholds flag every sample
        plan[10] = write_row(REG_MIDPOINT, 13'h1800);
        plan[11] = write_row(REG_UPPER, -13'sd100);
        plan[12] = write_row(REG_LOWER, 13'sd100);
        plan[13] = known_row(12'd2048, win_stats(0, 0, 0, 0, 11'd1024));
        // Unused index, then ramps and a write in the middle of a window
        plan[14] = write_row(REG_UNUSED, 13'h1FFF);
        plan[15] = fill_row(12'd0, 4, WINDOW_LEN);
        plan[16] = fill_row(12'd4095, 0, WINDOW_LEN / 2);
        plan[17] = write_row(REG_UPPER, 13'sd1000);
        plan[18] = write_row(REG_LOWER, -13'sd1000);
        plan[19] = fill_row(12'd4095, -8, WINDOW_LEN / 2);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed plan
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                write_reg(plan[r].index, plan[r].data);
            end else begin
                known_on = plan[r].known;
                known_want = plan[r].want;
                send_run(MODE_RAMP, plan[r].start, int'(plan[r].step), int'(plan[r].count));
            end
        end
        known_on = 0;

        // Random phases: new settings, then a run of samples
        while (windows_predicted < WINDOW_TARGET) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       value = 13'd0;
                    1:       value = 13'd4095;
                    2:       value = 13'd2048;
                    default: value = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_MIDPOINT, value);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       value = 13'h0FFF;
                    1:       value = 13'h1000;
                    2:       value = CFG_DATA_W'($urandom_range(0, 800)) - 13'd400;
                    default: value = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_UPPER, value);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       value = 13'h1000;
                    1:       value = 13'h0FFF;
                    2:       value = CFG_DATA_W'($urandom_range(0, 800)) - 13'd400;
                    default: value = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_LOWER, value);
            end
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            quiet = ($urandom_range(0, 3) == 0);
            mode = sample_mode_t'($urandom_range(0, 3));
            case (mode)
                MODE_NEAR: send_run(mode, mid_reg, $urandom_range(0, 400),
                                    $urandom_range(64, 2500));
                MODE_RAMP: send_run(mode, RAW_W'($urandom), int'($urandom_range(0, 128)) - 64,
                                    $urandom_range(64, 2500));
                default:   send_run(mode, '0, 0, $urandom_range(64, 2500));
            endcase
        end
        s_valid <= 1'b0;

        // Wait for the last windows, then let the pipeline settle
        while (expected_windows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed && expected_windows.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
